### rtl/c65alu_pkg.sv
// ----------------------------------------------------------------------------
// c65alu_pkg
// Types and constants shared by the 6502 ALU and register execute block.
// ----------------------------------------------------------------------------
package c65alu_pkg;

  typedef enum logic [5:0] {
    K_ADC  = 6'd0,  K_SBC  = 6'd1,  K_AND  = 6'd2,  K_EOR  = 6'd3,
    K_ORA  = 6'd4,  K_BIT  = 6'd5,  K_CMP  = 6'd6,  K_CPX  = 6'd7,
    K_CPY  = 6'd8,  K_LDA  = 6'd9,  K_LDX  = 6'd10, K_LDY  = 6'd11,
    K_AASL = 6'd12, K_ALSR = 6'd13, K_AROL = 6'd14, K_AROR = 6'd15,
    K_MASL = 6'd16, K_MLSR = 6'd17, K_MROL = 6'd18, K_MROR = 6'd19,
    K_INC  = 6'd20, K_DEC  = 6'd21, K_TAX  = 6'd22, K_TAY  = 6'd23,
    K_TXA  = 6'd24, K_TYA  = 6'd25, K_TSX  = 6'd26, K_TXS  = 6'd27,
    K_INX  = 6'd28, K_INY  = 6'd29, K_DEX  = 6'd30, K_DEY  = 6'd31,
    K_SEC  = 6'd32, K_CLC  = 6'd33, K_SEI  = 6'd34, K_CLI  = 6'd35,
    K_CLD  = 6'd36, K_CLV  = 6'd37, K_NOP  = 6'd38, K_WRST = 6'd39
  } kind_e;

  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  localparam logic [7:0] SpReset     = 8'hFD;
  localparam logic [7:0] StatusReset = 8'h34;
  localparam logic [7:0] WarmDec     = 8'd3;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] status;
  } regs_t;

endpackage

### rtl/c65alu_exec.sv
// ----------------------------------------------------------------------------
// c65alu_exec
// Combinational execute step: register file and one operation in, next
// register file and write-back byte out.
// ----------------------------------------------------------------------------
module c65alu_exec (
  input  c65alu_pkg::regs_t  regs_i,
  input  logic [5:0]         kind_i,
  input  logic [7:0]         operand_i,
  output c65alu_pkg::regs_t  regs_o,
  output logic [7:0]         mem_o
);
  import c65alu_pkg::*;

  logic [7:0] add_m;
  logic [8:0] sum;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic [7:0] sh_src;
  logic [7:0] sh_res;
  logic       sh_c;
  logic [7:0] nz_val;
  logic       nz_en;
  logic       cin;

  assign cin     = regs_i.status[FlagC];
  assign add_m   = (kind_i == K_SBC) ? ~operand_i : operand_i;
  assign sum     = {1'b0, regs_i.acc} + {1'b0, add_m} + {8'd0, cin};
  assign cmp_reg = (kind_i == K_CPX) ? regs_i.x :
                   (kind_i == K_CPY) ? regs_i.y : regs_i.acc;
  assign diff    = {1'b0, cmp_reg} + {1'b0, ~operand_i} + 9'd1;
  assign sh_src  = kind_i[4] ? operand_i : regs_i.acc;

  always_comb begin
    case (kind_i[1:0])
      2'd0: begin
        sh_c   = sh_src[7];
        sh_res = {sh_src[6:0], 1'b0};
      end
      2'd1: begin
        sh_c   = sh_src[0];
        sh_res = {1'b0, sh_src[7:1]};
      end
      2'd2: begin
        sh_c   = sh_src[7];
        sh_res = {sh_src[6:0], cin};
      end
      default: begin
        sh_c   = sh_src[0];
        sh_res = {cin, sh_src[7:1]};
      end
    endcase
  end

  always_comb begin
    regs_o = regs_i;
    mem_o  = operand_i;
    nz_val = 8'd0;
    nz_en  = 1'b0;
    unique case (kind_e'(kind_i))
      K_ADC, K_SBC: begin
        regs_o.acc           = sum[7:0];
        regs_o.status[FlagC] = sum[8];
        regs_o.status[FlagV] = ~(regs_i.acc[7] ^ add_m[7]) & (regs_i.acc[7] ^ sum[7]);
        nz_val = sum[7:0];
        nz_en  = 1'b1;
      end
      K_AND: begin
        regs_o.acc = regs_i.acc & operand_i;
        nz_val = regs_o.acc;
        nz_en  = 1'b1;
      end
      K_EOR: begin
        regs_o.acc = regs_i.acc ^ operand_i;
        nz_val = regs_o.acc;
        nz_en  = 1'b1;
      end
      K_ORA: begin
        regs_o.acc = regs_i.acc | operand_i;
        nz_val = regs_o.acc;
        nz_en  = 1'b1;
      end
      K_BIT: begin
        regs_o.status[FlagZ] = ((regs_i.acc & operand_i) == 8'd0);
        regs_o.status[FlagN] = operand_i[7];
        regs_o.status[FlagV] = operand_i[6];
      end
      K_CMP, K_CPX, K_CPY: begin
        regs_o.status[FlagC] = diff[8];
        nz_val = diff[7:0];
        nz_en  = 1'b1;
      end
      K_LDA: begin
        regs_o.acc = operand_i;
        nz_val = operand_i;
        nz_en  = 1'b1;
      end
      K_LDX: begin
        regs_o.x = operand_i;
        nz_val = operand_i;
        nz_en  = 1'b1;
      end
      K_LDY: begin
        regs_o.y = operand_i;
        nz_val = operand_i;
        nz_en  = 1'b1;
      end
      K_AASL, K_ALSR, K_AROL, K_AROR: begin
        regs_o.acc           = sh_res;
        regs_o.status[FlagC] = sh_c;
        nz_val = sh_res;
        nz_en  = 1'b1;
      end
      K_MASL, K_MLSR, K_MROL, K_MROR: begin
        mem_o                = sh_res;
        regs_o.status[FlagC] = sh_c;
        nz_val = sh_res;
        nz_en  = 1'b1;
      end
      K_INC: begin
        mem_o  = operand_i + 8'd1;
        nz_val = mem_o;
        nz_en  = 1'b1;
      end
      K_DEC: begin
        mem_o  = operand_i - 8'd1;
        nz_val = mem_o;
        nz_en  = 1'b1;
      end
      K_TAX: begin
        regs_o.x = regs_i.acc;
        nz_val = regs_i.acc;
        nz_en  = 1'b1;
      end
      K_TAY: begin
        regs_o.y = regs_i.acc;
        nz_val = regs_i.acc;
        nz_en  = 1'b1;
      end
      K_TXA: begin
        regs_o.acc = regs_i.x;
        nz_val = regs_i.x;
        nz_en  = 1'b1;
      end
      K_TYA: begin
        regs_o.acc = regs_i.y;
        nz_val = regs_i.y;
        nz_en  = 1'b1;
      end
      K_TSX: begin
        regs_o.x = regs_i.sp;
        nz_val = regs_i.sp;
        nz_en  = 1'b1;
      end
      K_TXS: regs_o.sp = regs_i.x;
      K_INX: begin
        regs_o.x = regs_i.x + 8'd1;
        nz_val = regs_o.x;
        nz_en  = 1'b1;
      end
      K_INY: begin
        regs_o.y = regs_i.y + 8'd1;
        nz_val = regs_o.y;
        nz_en  = 1'b1;
      end
      K_DEX: begin
        regs_o.x = regs_i.x - 8'd1;
        nz_val = regs_o.x;
        nz_en  = 1'b1;
      end
      K_DEY: begin
        regs_o.y = regs_i.y - 8'd1;
        nz_val = regs_o.y;
        nz_en  = 1'b1;
      end
      K_SEC: regs_o.status[FlagC] = 1'b1;
      K_CLC: regs_o.status[FlagC] = 1'b0;
      K_SEI: regs_o.status[FlagI] = 1'b1;
      K_CLI: regs_o.status[FlagI] = 1'b0;
      K_CLD: regs_o.status[FlagD] = 1'b0;
      K_CLV: regs_o.status[FlagV] = 1'b0;
      K_WRST: begin
        regs_o.sp            = regs_i.sp - WarmDec;
        regs_o.status[FlagI] = 1'b1;
      end
      default: ;
    endcase
    if (nz_en) begin
      regs_o.status[FlagZ] = (nz_val == 8'd0);
      regs_o.status[FlagN] = nz_val[7];
    end
  end

endmodule

### rtl/cpu6502_alu_register_execute_top.sv
// ----------------------------------------------------------------------------
// cpu6502_alu_register_execute_top
// Path: kind and operand are held in the input register, then the result in the output register.
// Throughput: one transaction per cycle while m_axis_tready does not stall the output; the execute
// step and the register file update are combinational between the input and result registers.
// Reset: A, X, Y cleared, SP to 0xFD, status to 0x34, both stages emptied.
// ----------------------------------------------------------------------------
module cpu6502_alu_register_execute_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // operand[7:0]
  input  logic [5:0]  s_axis_tuser,   // kind[5:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mem_out[7:0], acc_out[15:8], x_out[23:16], y_out[31:24],
  // sp_out[39:32], status_out[47:40]
  output logic [47:0] m_axis_tdata
);
  import c65alu_pkg::*;

  logic        in_vld_q;
  logic [5:0]  kind_q;
  logic [7:0]  operand_q;
  logic        out_vld_q;
  logic [47:0] out_q;
  regs_t       regs_q;
  regs_t       regs_d;
  logic [7:0]  mem_d;
  logic        out_load;

  assign out_load      = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | out_load;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  c65alu_exec u_exec (
    .regs_i    (regs_q),
    .kind_i    (kind_q),
    .operand_i (operand_q),
    .regs_o    (regs_d),
    .mem_o     (mem_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      regs_q.acc    <= 8'd0;
      regs_q.x      <= 8'd0;
      regs_q.y      <= 8'd0;
      regs_q.sp     <= SpReset;
      regs_q.status <= StatusReset;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
        regs_q    <= regs_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q    <= s_axis_tuser;
      operand_q <= s_axis_tdata;
    end
    if (out_load) begin
      out_q <= {regs_d.status, regs_d.sp, regs_d.y, regs_d.x, regs_d.acc, mem_d};
    end
  end

endmodule
